// ===== hdl/spm_pkg.sv =====
// Shared types and constants for the sample playback mixer.
package spm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_MIX    = 2'd1,
		OP_SETPOS = 2'd2,
		OP_REWIND = 2'd3
	} spm_op_t;

	typedef enum logic [2:0] {
		REG_STEP_RATE     = 3'd0,
		REG_VOLUME_LEVEL  = 3'd1,
		REG_MIX_SHIFT     = 3'd2,
		REG_SAMPLE_LENGTH = 3'd3,
		REG_BUFFER_SIZE   = 3'd4,
		REG_PLAY_ENABLE   = 3'd5
	} spm_reg_t;

	localparam int unsigned CFG_W       = 17;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [3:0]  VOLUME_MAX  = 4'd8;
	localparam logic [2:0]  SHIFT_MAX   = 3'd7;

	typedef struct packed {
		logic [15:0] step_rate;
		logic [3:0]  volume_level;
		logic [2:0]  mix_shift;
		logic [16:0] sample_length;
		logic [12:0] buffer_size;
		logic        play_enable;
	} spm_cfg_t;

	// One classified word handed from the front end to the back end.
	typedef struct packed {
		logic        is_load;
		logic        is_mix;
		logic [15:0] mem_x;
		logic [7:0]  sample_byte;
		logic [7:0]  mix_a;
		logic [7:0]  mix_b;
		logic [15:0] position;
		logic        rewound;
	} spm_cmd_t;

endpackage

// ===== hdl/sample_playback_mixer.sv =====
// Top level of the sample playback mixer: configuration registers, front end, queue, back end.
//
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_ready  op, sample_addr, sample_byte, mix_a_in, mix_b_in,
//                                          new_position
// output   out        out_valid / out_ready mix_a_out, mix_b_out, play_position, rewound
// config   in         cfg_we (no wait)     cfg_idx, cfg_wdata
//
// One word is accepted per cycle while the four-entry queue has room, and one result
// leaves per cycle while out_ready is high. A word enters the queue at the accepting edge,
// then passes four back-end stages (address reduction, address, sample memory read, mix
// output register). The phase accumulator in the front end is one register updated from
// combinational logic, so dependent words follow each other directly.
// Reset clears the phase, the queue and pipeline valids and loads the register defaults;
// the sample memory is not cleared. A stalled output freezes the back end, the queue
// fills, and only then does in_ready fall.
module sample_playback_mixer import spm_pkg::*; #(
	parameter int unsigned SAMPLE_DEPTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [15:0]         sample_addr,
	input  logic signed [7:0]   sample_byte,
	input  logic signed [7:0]   mix_a_in,
	input  logic signed [7:0]   mix_b_in,
	input  logic [15:0]         new_position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [7:0]   mix_a_out,
	output logic signed [7:0]   mix_b_out,
	output logic [15:0]         play_position,
	output logic                rewound
);

	spm_cfg_t cfg_q;
	spm_cmd_t front_cmd;
	spm_cmd_t q_head;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_not_empty;
	logic [7:0] mix_a_raw;
	logic [7:0] mix_b_raw;

	// Register writes. Volume saturates at full scale; other registers take the
	// low bits of the written word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_rate     <= 16'd256;
			cfg_q.volume_level  <= VOLUME_MAX;
			cfg_q.mix_shift     <= 3'd0;
			cfg_q.sample_length <= 17'h10000;
			cfg_q.buffer_size   <= 13'd256;
			cfg_q.play_enable   <= 1'b1;
		end else if (cfg_we) begin
			unique case (spm_reg_t'(cfg_idx))
				REG_STEP_RATE: begin
					cfg_q.step_rate <= cfg_wdata[15:0];
				end
				REG_VOLUME_LEVEL: begin
					cfg_q.volume_level <= (cfg_wdata[3:0] > VOLUME_MAX) ? VOLUME_MAX
						: cfg_wdata[3:0];
				end
				REG_MIX_SHIFT: begin
					cfg_q.mix_shift <= cfg_wdata[2:0];
				end
				REG_SAMPLE_LENGTH: begin
					cfg_q.sample_length <= cfg_wdata[16:0];
				end
				REG_BUFFER_SIZE: begin
					cfg_q.buffer_size <= cfg_wdata[12:0];
				end
				REG_PLAY_ENABLE: begin
					cfg_q.play_enable <= cfg_wdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The front end owns the phase and turns each word into a queue entry.
	spm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.sample_addr  (sample_addr),
		.sample_byte  (sample_byte),
		.mix_a_in     (mix_a_in),
		.mix_b_in     (mix_b_in),
		.new_position (new_position),
		.q_full       (q_full),
		.push         (push),
		.cmd          (front_cmd)
	);

	spm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// The back end keeps loads and mix reads in order at the single memory port.
	spm_back #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mix_a_out     (mix_a_raw),
		.mix_b_out     (mix_b_raw),
		.play_position (play_position),
		.rewound       (rewound)
	);

	assign mix_a_out = $signed(mix_a_raw);
	assign mix_b_out = $signed(mix_b_raw);

endmodule

// ===== hdl/spm_front.sv =====
// Front end: accepts words, runs the phase accumulator and classifies each word.
module spm_front import spm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  spm_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] sample_addr,
	input  logic [7:0]  sample_byte,
	input  logic [7:0]  mix_a_in,
	input  logic [7:0]  mix_b_in,
	input  logic [15:0] new_position,
	input  logic        q_full,
	output logic        push,
	output spm_cmd_t    cmd
);

	logic [23:0] phase_q;
	logic [23:0] phase_next;
	logic [24:0] sum;
	logic [17:0] reach;
	logic        mix_play;
	logic        do_rewind;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign sum   = {1'b0, phase_q} + {9'd0, cfg.step_rate};
	assign reach = {1'b0, sum[24:8]} + {5'd0, cfg.buffer_size};

	always_comb begin
		phase_next = phase_q;
		mix_play   = 1'b0;
		do_rewind  = 1'b0;
		unique case (spm_op_t'(op))
			OP_LOAD: begin
				phase_next = phase_q;
			end
			OP_MIX: begin
				if (cfg.play_enable) begin
					phase_next = sum[23:0];
					mix_play   = 1'b1;
				end
			end
			OP_SETPOS: begin
				phase_next = {new_position, 8'd0};
			end
			OP_REWIND: begin
				if (reach > {1'b0, cfg.sample_length}) begin
					phase_next = phase_q - {cfg.sample_length[15:0], 8'd0};
					do_rewind  = 1'b1;
				end
			end
			default: begin
				phase_next = phase_q;
			end
		endcase
	end

	always_comb begin
		cmd.is_load     = (spm_op_t'(op) == OP_LOAD);
		cmd.is_mix      = mix_play;
		cmd.mem_x       = cmd.is_load ? sample_addr : phase_next[23:8];
		cmd.sample_byte = sample_byte;
		cmd.mix_a       = mix_a_in;
		cmd.mix_b       = mix_b_in;
		cmd.position    = phase_next[23:8];
		cmd.rewound     = do_rewind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= phase_next;
		end
	end

endmodule

// ===== hdl/spm_queue.sv =====
// Short queue of classified words between the front end and the back end.
module spm_queue import spm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  spm_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output spm_cmd_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	spm_cmd_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/spm_back.sv =====
// Back end: address reduction, sample memory, attenuation and mixing.
module spm_back import spm_pkg::*; #(
	parameter int unsigned SAMPLE_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  spm_cfg_t    cfg,
	input  logic        q_not_empty,
	input  spm_cmd_t    q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  mix_a_out,
	output logic [7:0]  mix_b_out,
	output logic [15:0] play_position,
	output logic        rewound
);

	localparam int unsigned AW   = $clog2(SAMPLE_DEPTH);
	localparam bit          POW2 = ((SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0);
	// Only a depth below the 16-bit address range that is not a power of two
	// needs a real reduction; otherwise the address is already in range.
	localparam bit          NEED_RED = !POW2 && (SAMPLE_DEPTH < 65536);
	localparam int unsigned QW   = 8;
	localparam int unsigned SH   = 16 + AW;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH);

	logic            en;
	logic            v_s1, v_s2, v_s3;
	spm_cmd_t        cmd_s1, cmd_s2, cmd_s3;
	logic [AW-1:0]   addr_next;
	logic [AW-1:0]   addr_s2;
	logic [7:0]      mem_q [SAMPLE_DEPTH];
	logic [7:0]      rd_s3;
	logic [4:0]      shift_total;
	logic [2:0]      shift_amt;
	logic [7:0]      atten;

	// The whole pipe moves together whenever the output register is free.
	assign en  = !out_valid || out_ready;
	assign pop = en && q_not_empty;

	generate
		if (NEED_RED) begin : g_red
			logic [63:0]   prod;
			logic [QW-1:0] q_next;
			logic [QW-1:0] q_s1;
			logic [23:0]   back;
			assign prod      = 64'(q_head.mem_x) * RECIP;
			assign q_next    = QW'(prod >> SH);
			always_ff @(posedge clk) begin
				if (en) begin
					q_s1 <= q_next;
				end
			end
			assign back      = 24'(q_s1) * 24'(SAMPLE_DEPTH);
			assign addr_next = AW'(24'(cmd_s1.mem_x) - back);
		end else begin : g_plain
			assign addr_next = AW'(cmd_s1.mem_x);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= q_not_empty;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= q_head;
			cmd_s2  <= cmd_s1;
			addr_s2 <= addr_next;
			cmd_s3  <= cmd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s2 && cmd_s2.is_load) begin
				mem_q[addr_s2] <= cmd_s2.sample_byte;
			end
			rd_s3 <= mem_q[addr_s2];
		end
	end

	assign shift_total = {1'b0, VOLUME_MAX - cfg.volume_level} + {2'b00, cfg.mix_shift};
	assign shift_amt   = (shift_total > {2'b00, SHIFT_MAX}) ? SHIFT_MAX : shift_total[2:0];
	assign atten       = 8'($signed(rd_s3) >>> shift_amt);

	always_ff @(posedge clk) begin
		if (en) begin
			mix_a_out     <= cmd_s3.is_mix ? cmd_s3.mix_a + atten : cmd_s3.mix_a;
			mix_b_out     <= cmd_s3.is_mix ? cmd_s3.mix_b + atten : cmd_s3.mix_b;
			play_position <= cmd_s3.position;
			rewound       <= cmd_s3.rewound;
		end
	end

endmodule
